>>> hdl/sste_pkg.sv
// Shared types, constants and functions for the seven-segment text encoder.
// Used by sste_rsp_queue, the encoder top, digit_checker and tb; no dependencies.
package sste_pkg;

   // Display and coding constants
   localparam logic [7:0] MaxDigits   = 8'd16;
   localparam int         TableSize   = 34;
   localparam logic [7:0] DotChar     = 8'h2E;
   localparam logic [7:0] PointBit    = 8'b1000_0000;
   localparam logic [7:0] UnknownCode = 8'hFF;
   localparam logic [7:0] BlankLevel  = 8'b0000_0000;

   // Result queue sizing
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Configuration register indexes
   typedef enum logic [3:0] {
      CSR_DIGIT_COUNT = 4'd0,
      CSR_FORCE_UPPER = 4'd1
   } csr_index_type;

   // Segment patterns, indexed by the position of the character in the key list
   // (0-9, a-j, l, n-u, x-z, dash, space)
   localparam logic [7:0] LowerStyle [TableSize] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h67, 8'h76, 8'h10, 8'h1E,
      8'h30, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h76,
      8'h6E, 8'h5B, 8'h40, 8'h00
   };

   localparam logic [7:0] UpperStyle [TableSize] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h67, 8'h76, 8'h30, 8'h1E,
      8'h38, 8'h37, 8'h3F, 8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h76,
      8'h6E, 8'h5B, 8'h40, 8'h00
   };

   // Request and result payloads
   typedef struct packed {
      logic [7:0] character;
      logic [7:0] intensity;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0]  digit_index;
      logic        shown;
      logic [7:0]  segments;
      logic        unknown_char;
      logic [23:0] pixel_low;
      logic [23:0] pixel_mid;
      logic [23:0] pixel_high;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       known;
      logic [7:0] code;
   } lookup_type;

   // Fold case, find the character in the key list and fetch its pattern
   function automatic lookup_type lookup_char(input logic [7:0] ch, input logic upper);
      logic [7:0] c;
      logic [5:0] idx;
      lookup_type r;
      c = ch;
      if (c >= 8'h41 && c <= 8'h5A) begin
         c = c + 8'd32;
      end
      r.known = 1'b1;
      idx     = 6'd0;
      case (c)
         8'h30: idx = 6'd0;
         8'h31: idx = 6'd1;
         8'h32: idx = 6'd2;
         8'h33: idx = 6'd3;
         8'h34: idx = 6'd4;
         8'h35: idx = 6'd5;
         8'h36: idx = 6'd6;
         8'h37: idx = 6'd7;
         8'h38: idx = 6'd8;
         8'h39: idx = 6'd9;
         8'h61: idx = 6'd10;
         8'h62: idx = 6'd11;
         8'h63: idx = 6'd12;
         8'h64: idx = 6'd13;
         8'h65: idx = 6'd14;
         8'h66: idx = 6'd15;
         8'h67: idx = 6'd16;
         8'h68: idx = 6'd17;
         8'h69: idx = 6'd18;
         8'h6A: idx = 6'd19;
         8'h6C: idx = 6'd20;
         8'h6E: idx = 6'd21;
         8'h6F: idx = 6'd22;
         8'h70: idx = 6'd23;
         8'h71: idx = 6'd24;
         8'h72: idx = 6'd25;
         8'h73: idx = 6'd26;
         8'h74: idx = 6'd27;
         8'h75: idx = 6'd28;
         8'h78: idx = 6'd29;
         8'h79: idx = 6'd30;
         8'h7A: idx = 6'd31;
         8'h2D: idx = 6'd32;
         8'h20: idx = 6'd33;
         default: r.known = 1'b0;
      endcase
      if (!r.known) begin
         r.code = UnknownCode;
      end else if (upper) begin
         r.code = UpperStyle[idx];
      end else begin
         r.code = LowerStyle[idx];
      end
      return r;
   endfunction

   // Level of one segment: the given intensity when lit, blank level otherwise
   function automatic logic [7:0] seg_level(input logic lit, input logic [7:0] inten);
      return lit ? inten : BlankLevel;
   endfunction

   // Build one finished digit
   function automatic rsp_type make_rsp(input logic [7:0] code,
                                        input logic [7:0] inten,
                                        input logic       unknown,
                                        input logic [7:0] index,
                                        input logic [7:0] limit,
                                        input logic       is_last);
      rsp_type r;
      r.digit_index  = index;
      r.shown        = index < limit;
      r.segments     = code;
      r.unknown_char = unknown;
      r.pixel_low    = {seg_level(code[0], inten), seg_level(code[1], inten),
                        seg_level(code[2], inten)};
      r.pixel_mid    = {seg_level(code[3], inten), seg_level(code[4], inten),
                        seg_level(code[5], inten)};
      r.pixel_high   = {seg_level(code[6], inten), seg_level(code[7], inten),
                        BlankLevel};
      r.last         = is_last;
      return r;
   endfunction

endpackage

>>> hdl/sste_rsp_queue.sv
// Small result queue that takes up to two results per cycle and gives one.
// Depends on sste_pkg for rsp_type and the queue sizing constants.
module sste_rsp_queue
   import sste_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push_first,
   input  rsp_type    push_second,
   output logic       room_for_two,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   rsp_type                   mem [QueueDepth];
   logic [QueuePtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]  count_ff, count_in;
   logic [QueuePtrWidth-1:0]  wr_ptr_next;
   logic                      pop;

   assign pop          = rsp_valid && rsp_ready;
   assign rsp_valid    = count_ff != '0;
   assign rsp_data     = mem[rd_ptr_ff];
   assign room_for_two = count_ff <= QueueCntWidth'(QueueDepth - 2);
   assign wr_ptr_next  = wr_ptr_ff + 1'b1;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrWidth'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QueueCntWidth'(push_count) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: first result at the write pointer, second right after it
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_next] <= push_second;
      end
   end

endmodule

>>> hdl/seven_segment_text_encoder_top.sv
// Seven-segment text encoder, top level.
// Depends on sste_pkg and sste_rsp_queue.
//
// Text enters one character per request and leaves as finished digits with
// their segment code and packed pixel levels. A request is accepted in any
// cycle in which the four-entry result queue has room for two results, so
// with a draining output one character is taken every cycle; the results
// of a request can be taken from the cycle after it is accepted. A character
// gives zero, one or two digits (one digit is held back so that a following
// dot can merge into its point), and the output port delivers one digit per
// cycle while the receiver is ready. A request that gives two digits always
// ends a text and leaves nothing held, so the request after it gives at most
// one and a draining output keeps pace with one character per cycle. The
// configuration port is always ready; write it only while the block is idle.
module seven_segment_text_encoder_top
   import sste_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_index,
   input  logic [4:0] csr_data
);

   logic [4:0] digit_count_ff, digit_count_in;
   logic       force_upper_ff, force_upper_in;
   logic [7:0] held_code_ff, held_code_in;
   logic [7:0] held_intensity_ff, held_intensity_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_unknown_ff, held_unknown_in;
   logic [7:0] next_digit_ff, next_digit_in;

   logic       accept;
   logic       is_dot;
   logic       merge;
   logic       emit_held;
   lookup_type found;
   logic [7:0] limit;
   logic [7:0] mid_code, mid_intensity, mid_digit;
   logic       mid_unknown;
   rsp_type    held_rsp, final_rsp;
   logic [1:0] push_count;
   rsp_type    push_first;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // Configuration registers
   always_comb begin
      digit_count_in = digit_count_ff;
      force_upper_in = force_upper_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DIGIT_COUNT: digit_count_in = csr_data;
            CSR_FORCE_UPPER: force_upper_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Display limit, clamped to the largest supported display
   assign limit = ({3'b000, digit_count_ff} < MaxDigits) ? {3'b000, digit_count_ff}
                                                         : MaxDigits;

   // Classify the character
   assign is_dot    = req_data.character == DotChar;
   assign merge     = is_dot && held_valid_ff && !held_code_ff[7];
   assign emit_held = !merge && held_valid_ff;
   assign found     = lookup_char(req_data.character, force_upper_ff);

   // Held digit after this character, before any end of text
   always_comb begin
      if (merge) begin
         mid_code      = held_code_ff | PointBit;
         mid_intensity = held_intensity_ff;
         mid_unknown   = held_unknown_ff;
      end else if (is_dot) begin
         mid_code      = PointBit;
         mid_intensity = req_data.intensity;
         mid_unknown   = 1'b0;
      end else begin
         mid_code      = found.code;
         mid_intensity = req_data.intensity;
         mid_unknown   = !found.known;
      end
      if (emit_held && next_digit_ff != 8'hFF) begin
         mid_digit = next_digit_ff + 8'd1;
      end else begin
         mid_digit = next_digit_ff;
      end
   end

   // Finished digits of this request
   assign held_rsp  = make_rsp(held_code_ff, held_intensity_ff, held_unknown_ff,
                               next_digit_ff, limit, 1'b0);
   assign final_rsp = make_rsp(mid_code, mid_intensity, mid_unknown,
                               mid_digit, limit, 1'b1);

   always_comb begin
      push_count = 2'd0;
      push_first = final_rsp;
      if (accept) begin
         push_count = 2'(emit_held) + 2'(req_data.end_of_text);
         if (emit_held) begin
            push_first = held_rsp;
         end
      end
   end

   // Next held state
   always_comb begin
      held_code_in      = held_code_ff;
      held_intensity_in = held_intensity_ff;
      held_unknown_in   = held_unknown_ff;
      held_valid_in     = held_valid_ff;
      next_digit_in     = next_digit_ff;
      if (accept) begin
         if (req_data.end_of_text) begin
            held_code_in      = '0;
            held_intensity_in = '0;
            held_unknown_in   = 1'b0;
            held_valid_in     = 1'b0;
            next_digit_in     = '0;
         end else begin
            held_code_in      = mid_code;
            held_intensity_in = mid_intensity;
            held_unknown_in   = mid_unknown;
            held_valid_in     = 1'b1;
            next_digit_in     = mid_digit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff    <= 5'd1;
         force_upper_ff    <= 1'b0;
         held_code_ff      <= '0;
         held_intensity_ff <= '0;
         held_unknown_ff   <= 1'b0;
         held_valid_ff     <= 1'b0;
         next_digit_ff     <= '0;
      end else begin
         digit_count_ff    <= digit_count_in;
         force_upper_ff    <= force_upper_in;
         held_code_ff      <= held_code_in;
         held_intensity_ff <= held_intensity_in;
         held_unknown_ff   <= held_unknown_in;
         held_valid_ff     <= held_valid_in;
         next_digit_ff     <= next_digit_in;
      end
   end

   // Result queue
   sste_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_first   (push_first),
      .push_second  (final_rsp),
      .room_for_two (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

>>> tb/digit_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the seven-segment text encoder: predicts finished digits from
// accepted requests and register writes and checks them against the result channel.
// Depends on sste_pkg for the payload types, register indexes and coding constants.
module digit_checker
   import sste_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [4:0]  csr_data,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   localparam int GlyphCount = 34;

   // Characters the display knows: 0-9, a-j, l, n-u, x-z, dash, space
   localparam logic [7:0] GlyphKeys [GlyphCount] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
      8'h6C, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h78,
      8'h79, 8'h7A, 8'h2D, 8'h20
   };

   localparam logic [7:0] LowerGlyphs [GlyphCount] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h67, 8'h76, 8'h10, 8'h1E,
      8'h30, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h76,
      8'h6E, 8'h5B, 8'h40, 8'h00
   };

   localparam logic [7:0] UpperGlyphs [GlyphCount] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h67, 8'h76, 8'h30, 8'h1E,
      8'h38, 8'h37, 8'h3F, 8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h76,
      8'h6E, 8'h5B, 8'h40, 8'h00
   };

   // Register copies
   logic [4:0] shown_count;
   logic       upper_style;

   // Digit held back for a possible dot, and position in the text
   logic [7:0] hold_seg;
   logic [7:0] hold_bright;
   logic       hold_full;
   logic       hold_unknown;
   logic [7:0] digit_pos;

   rsp_type     expected_digits [$];
   int unsigned fails = 0;

   // Pattern of one character as {known, segments}; letters fold to lower case
   function automatic logic [8:0] glyph(input logic [7:0] ch, input logic upper);
      logic [7:0] folded;
      folded = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
      for (int i = 0; i < GlyphCount; i++) begin
         if (GlyphKeys[i] == folded) begin
            return {1'b1, upper ? UpperGlyphs[i] : LowerGlyphs[i]};
         end
      end
      return {1'b0, UnknownCode};
   endfunction

   // Queue the held digit as a finished digit and advance the position
   task automatic finish_digit(input logic is_last);
      rsp_type    d;
      logic [7:0] limit;
      limit          = ({3'b0, shown_count} < MaxDigits) ? {3'b0, shown_count} : MaxDigits;
      d.digit_index  = digit_pos;
      d.shown        = digit_pos < limit;
      d.segments     = hold_seg;
      d.unknown_char = hold_unknown;
      d.pixel_low    = {hold_bright & {8{hold_seg[0]}}, hold_bright & {8{hold_seg[1]}},
                        hold_bright & {8{hold_seg[2]}}};
      d.pixel_mid    = {hold_bright & {8{hold_seg[3]}}, hold_bright & {8{hold_seg[4]}},
                        hold_bright & {8{hold_seg[5]}}};
      d.pixel_high   = {hold_bright & {8{hold_seg[6]}}, hold_bright & {8{hold_seg[7]}}, 8'h00};
      d.last         = is_last;
      expected_digits.push_back(d);
      if (digit_pos != 8'hFF) begin
         digit_pos = digit_pos + 8'd1;
      end
   endtask

   // One accepted character: merge a dot or hold a new digit, then close the text
   task automatic take_char(input req_type r);
      logic [8:0] found;
      if (r.character == DotChar && hold_full && !hold_seg[7]) begin
         hold_seg = hold_seg | PointBit;
      end else begin
         found = (r.character == DotChar) ? {1'b1, PointBit} : glyph(r.character, upper_style);
         if (hold_full) begin
            finish_digit(1'b0);
         end
         hold_seg     = found[7:0];
         hold_bright  = r.intensity;
         hold_unknown = !found[8];
         hold_full    = 1'b1;
      end
      if (r.end_of_text) begin
         finish_digit(1'b1);
         hold_full    = 1'b0;
         hold_seg     = 8'h00;
         hold_bright  = 8'h00;
         hold_unknown = 1'b0;
         digit_pos    = 8'h00;
      end
   endtask

   // Compare one delivered digit with the oldest prediction
   task automatic check_digit(input rsp_type got);
      rsp_type want;
      if (expected_digits.size() == 0) begin
         $error("digit with no prediction waiting: digit_index %0d segments %0h",
                got.digit_index, got.segments);
         fails++;
         return;
      end
      want = expected_digits.pop_front();
      if (got.digit_index !== want.digit_index) begin
         $error("digit_index: expected %0d, got %0d", want.digit_index, got.digit_index);
         fails++;
      end
      if (got.shown !== want.shown) begin
         $error("shown: expected %0d, got %0d", want.shown, got.shown);
         fails++;
      end
      if (got.segments !== want.segments) begin
         $error("segments: expected %0h, got %0h", want.segments, got.segments);
         fails++;
      end
      if (got.unknown_char !== want.unknown_char) begin
         $error("unknown_char: expected %0d, got %0d", want.unknown_char, got.unknown_char);
         fails++;
      end
      if (got.pixel_low !== want.pixel_low) begin
         $error("pixel_low: expected %06h, got %06h", want.pixel_low, got.pixel_low);
         fails++;
      end
      if (got.pixel_mid !== want.pixel_mid) begin
         $error("pixel_mid: expected %06h, got %06h", want.pixel_mid, got.pixel_mid);
         fails++;
      end
      if (got.pixel_high !== want.pixel_high) begin
         $error("pixel_high: expected %06h, got %06h", want.pixel_high, got.pixel_high);
         fails++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         fails++;
      end
   endtask

   // Watch all three channels; results go first since none can stem from a
   // request accepted at the same edge
   always @(posedge clock) begin
      if (reset) begin
         shown_count  = 5'd1;
         upper_style  = 1'b0;
         hold_seg     = 8'h00;
         hold_bright  = 8'h00;
         hold_full    = 1'b0;
         hold_unknown = 1'b0;
         digit_pos    = 8'h00;
         expected_digits.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_digit(rsp_data);
         end
         if (req_valid && req_ready) begin
            take_char(req_data);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIGIT_COUNT: shown_count = csr_data;
               CSR_FORCE_UPPER: upper_style = csr_data[0];
               default: ;
            endcase
         end
      end
      fail_count  <= fails;
      outstanding <= expected_digits.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the seven-segment text encoder testbench: clock, reset, stimulus and verdict.
// Depends on sste_pkg, seven_segment_text_encoder_top and digit_checker.
module tb
   import sste_pkg::*;
();

   localparam int unsigned LongHold = 40;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_index = '0;
   logic [4:0] csr_data  = '0;

   int unsigned fail_count;
   int unsigned outstanding;

   // Idling knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   // Long receiver hold-off: stimulus bumps hold_asks, receiver counts it out
   int unsigned hold_asks = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   seven_segment_text_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   digit_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         rsp_ready <= 1'b0;
         hold_seen <= hold_asks;
         hold_left <= LongHold;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request, with random idle cycles first, and wait until taken
   task automatic send_req(input logic [7:0] ch, input logic [7:0] level, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{character: ch, intensity: level, end_of_text: eot};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted digit has come, plus a margin
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [4:0] count, input logic upper);
      csr_valid <= 1'b1;
      csr_index <= CSR_DIGIT_COUNT;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_FORCE_UPPER;
      csr_data  <= {4'b0, upper};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Character mix: dots, digits, both letter cases, dash/space, anything
   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 22) return DotChar;
      if (roll < 42) return 8'(8'h30 + $urandom_range(9));
      if (roll < 62) return 8'(8'h61 + $urandom_range(25));
      if (roll < 75) return 8'(8'h41 + $urandom_range(25));
      if (roll < 82) return ($urandom_range(1) != 0) ? 8'h2D : 8'h20;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_level();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Mostly whole texts ending in end_of_text; now and then a noisy burst
   task automatic send_texts(input int unsigned quota);
      int unsigned sent;
      int unsigned n;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(7) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) send_req(pick_char(), pick_level(), $urandom_range(3) == 0);
         end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int k = 0; k < n; k++) begin
               send_req(pick_char(), pick_level(), k == n - 1);
            end
         end
         sent += n;
      end
   endtask

   // Stimulus and verdict
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_config(5'd1, 1'b0);

      // Directed: merges, lone dots, unknowns, case folding, field extremes
      send_req(8'h38, 8'hFF, 1'b0);    // '8'
      send_req(DotChar, 8'h00, 1'b0);  // merges, intensity ignored
      send_req(DotChar, 8'h4D, 1'b0);  // point already set: own digit
      send_req(8'h41, 8'h01, 1'b0);    // 'A' folds to 'a'
      send_req(8'hFF, 8'h80, 1'b0);    // unknown, point lit
      send_req(DotChar, 8'hC8, 1'b0);  // cannot merge into unknown
      send_req(8'h00, 8'hFF, 1'b1);    // unknown, ends text
      send_req(DotChar, 8'h21, 1'b1);  // dot with nothing held
      send_req(8'h5A, 8'h00, 1'b0);    // 'Z'
      send_req(8'h20, 8'hAA, 1'b0);    // space
      send_req(8'h2D, 8'h55, 1'b0);    // dash
      send_req(8'h6B, 8'h0F, 1'b0);    // 'k' is not in the table
      send_req(DotChar, 8'hF0, 1'b1);
      send_req(8'h39, 8'h5A, 1'b0);    // '9'
      send_req(DotChar, 8'hA5, 1'b1);  // merge on the last character
      send_req(8'h6D, 8'h03, 1'b1);    // single-character text
      settle();

      // Full display, upper-case style, no idling, one long output hold-off
      write_config(5'd16, 1'b1);
      send_texts(100);
      hold_asks++;
      send_texts(100);
      settle();

      // Nothing shown, sender idling, pause for a full drain midway
      write_config(5'd0, 1'b0);
      send_idle_pct = 55;
      send_texts(100);
      settle();
      send_texts(100);
      settle();

      // Count above the display size, receiver stalling
      write_config(5'd31, 1'b1);
      send_idle_pct = 0;
      stall_pct     = 55;
      send_texts(200);
      settle();

      // Random setting, both sides idling, another hold-off
      write_config(5'($urandom_range(1, 15)), 1'($urandom_range(1)));
      send_idle_pct = 34;
      stall_pct     = 34;
      send_texts(100);
      hold_asks++;
      send_texts(100);
      settle();

      // Text longer than 255 digits so the index saturates
      write_config(5'd5, 1'b0);
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int k = 0; k < 270; k++) begin
         send_req(8'(8'h41 + $urandom_range(25)), pick_level(), k == 269);
      end
      send_texts(50);
      settle();

      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/sste_pkg.sv
hdl/sste_rsp_queue.sv
hdl/seven_segment_text_encoder_top.sv
tb/digit_checker.sv
tb/tb.sv
